// ----- sv/rprt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rprt_pkg;

    localparam int MAX_WIDTH_DEF = 512;
    localparam int QDEPTH        = 4;
    localparam int QCNT_W        = $clog2(QDEPTH + 1);

    // register indexes
    localparam logic [1:0] REG_LIGHT_RANGE = 2'd0;
    localparam logic [1:0] REG_GRAY_MODE   = 2'd1;
    localparam logic [1:0] REG_ROW_WIDTH   = 2'd2;

    localparam logic [9:0] ROW_WIDTH_RST = 10'd320;

    // item kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    // luma weights, Q14
    localparam int         PROD_W  = 22;
    localparam logic [13:0] COEF_R = 14'd4899;
    localparam logic [13:0] COEF_G = 14'd9617;
    localparam logic [13:0] COEF_B = 14'd1868;
    localparam logic [13:0] ROUND  = 14'd8192;

    typedef struct packed {
        logic              ren;
        logic              wen;
        logic              rlast;
        logic signed [8:0] limit;
        logic [7:0]        wdata;
    } cmd_ctl_t;

    typedef struct packed {
        logic a_valid;
        logic b_valid;
    } front_occ_t;

endpackage

`default_nettype wire

// ----- sv/rprt_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface rprt_pix_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] chan0;
    logic [7:0] chan1;
    logic [7:0] chan2;

    modport source (output valid, kind, chan0, chan1, chan2, input ready);
    modport sink   (input valid, kind, chan0, chan1, chan2, output ready);
endinterface

interface rprt_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_out;
    logic       row_end;

    modport source (output valid, pixel_out, row_end, input ready);
    modport sink   (input valid, pixel_out, row_end, output ready);
endinterface

interface rprt_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [9:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- sv/row_peak_relative_threshold.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Row peak-relative threshold. Takes one pixel or drain beat per clock while
// in_ready is high (queue credit); each beat gives at most one result, a pixel
// of the previously completed row, zeroed when it lies more than light_range
// below that row's peak. A result passes two front stages (luma products, then
// gray and row bookkeeping), a four-entry command queue and the line-store read
// before the output register. The line store is 2**AW bytes, AW being
// $clog2(MAX_WIDTH)+1, in one memory with one write and one read port; it
// needs no clearing pass, so beats are taken straight out of reset. Rows with
// fewer pixels than row_width are held until completed; drain beats then flush them.
module row_peak_relative_threshold #(
    parameter int MAX_WIDTH = rprt_pkg::MAX_WIDTH_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    rprt_pix_if.sink    pixels,
    rprt_cfg_if.sink    cfg,
    rprt_res_if.source  results
);
    import rprt_pkg::*;

    localparam int AW     = $clog2(MAX_WIDTH) + 1;
    localparam int CTL_W  = $bits(cmd_ctl_t);
    localparam int DATA_W = CTL_W + 2 * AW;
    localparam int OCC_W  = QCNT_W + 1;

    logic              in_ready;
    logic              q_push, q_pop, q_head_valid;
    cmd_ctl_t          f_ctl, b_ctl;
    logic [AW-1:0]     f_raddr, f_waddr, b_raddr, b_waddr;
    logic [DATA_W-1:0] q_head;
    logic [QCNT_W-1:0] q_count;
    front_occ_t        occ;
    logic [OCC_W-1:0]  occ_sum;

    // credit: everything in flight must fit in the queue
    assign occ_sum  = OCC_W'(q_count) + OCC_W'(occ.a_valid) + OCC_W'(occ.b_valid);
    assign in_ready = occ_sum < OCC_W'(QDEPTH);

    rprt_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .pixels   (pixels),
        .cfg      (cfg),
        .in_ready (in_ready),
        .push     (q_push),
        .ctl      (f_ctl),
        .raddr    (f_raddr),
        .waddr    (f_waddr),
        .occ      (occ)
    );

    rprt_queue #(
        .DATA_W (DATA_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  ({f_ctl, f_raddr, f_waddr}),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_data  (q_head),
        .count      (q_count)
    );

    assign b_ctl   = q_head[DATA_W-1 -: CTL_W];
    assign b_raddr = q_head[2*AW-1 -: AW];
    assign b_waddr = q_head[AW-1:0];

    rprt_back #(
        .AW (AW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .ctl        (b_ctl),
        .raddr      (b_raddr),
        .waddr      (b_waddr),
        .pop        (q_pop),
        .results    (results)
    );

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (q_count < QCNT_W'(QDEPTH)))
        else $error("command queue overflow");

    a_credit: assert property (@(posedge clk) disable iff (!rst_n)
        occ_sum <= OCC_W'(QDEPTH))
        else $error("in-flight beats exceed queue space");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_head_valid)
        else $error("pop from empty command queue");
`endif

endmodule

`default_nettype wire

// ----- sv/rprt_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rprt_front #(
    parameter int MAX_WIDTH = rprt_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    rprt_pix_if.sink                    pixels,
    rprt_cfg_if.sink                    cfg,
    input  wire logic                   in_ready,
    output logic                        push,
    output rprt_pkg::cmd_ctl_t          ctl,
    output logic [$clog2(MAX_WIDTH):0]  raddr,
    output logic [$clog2(MAX_WIDTH):0]  waddr,
    output rprt_pkg::front_occ_t        occ
);
    import rprt_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = (CW + 1 > 10) ? CW + 1 : 10;

    logic [7:0]        light_range_reg;
    logic              gray_mode_reg;
    logic [9:0]        row_width_reg;

    logic              a_valid_reg;
    logic              a_kind_reg;
    logic [7:0]        a_c0_reg;
    logic [PROD_W-1:0] a_p0_reg, a_p1_reg, a_p2_reg;

    logic              b_valid_reg;
    logic              b_kind_reg;
    logic [7:0]        b_gray_reg;

    logic [7:0]        running_reg, running_next;
    logic [7:0]        held_reg, held_next;
    logic [CW-1:0]     wcol_reg, wcol_next;
    logic [CW-1:0]     rcol_reg, rcol_next;
    logic              bank_reg, bank_next;
    logic              pending_reg, pending_next;

    logic [PROD_W-1:0] sum;
    logic [7:0]        gray;
    logic [WW-1:0]     rw_ext, width;
    logic [WW-1:0]     wcol_inc, rcol_inc;
    logic              wend, rlast, is_pix;
    logic [7:0]        peak_new;

    assign cfg.ready    = 1'b1;
    assign pixels.ready = in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_range_reg <= 8'd0;
            gray_mode_reg   <= 1'b0;
            row_width_reg   <= ROW_WIDTH_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_LIGHT_RANGE: light_range_reg <= cfg.data[7:0];
                REG_GRAY_MODE:   gray_mode_reg   <= cfg.data[0];
                REG_ROW_WIDTH:   row_width_reg   <= cfg.data;
                default:         ;
            endcase
        end
    end

    // stage A: weighted products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else
            a_valid_reg <= pixels.valid && in_ready;
    end

    always_ff @(posedge clk)
    begin
        if (pixels.valid && in_ready)
        begin
            a_kind_reg <= pixels.kind;
            a_c0_reg   <= pixels.chan0;
            a_p0_reg   <= PROD_W'(pixels.chan0) * PROD_W'(COEF_R);
            a_p1_reg   <= PROD_W'(pixels.chan1) * PROD_W'(COEF_G);
            a_p2_reg   <= PROD_W'(pixels.chan2) * PROD_W'(COEF_B);
        end
    end

    // stage B: gray value
    assign sum  = a_p0_reg + a_p1_reg + a_p2_reg + PROD_W'(ROUND);
    assign gray = gray_mode_reg ? a_c0_reg : sum[PROD_W-1:14];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (a_valid_reg)
        begin
            b_kind_reg <= a_kind_reg;
            b_gray_reg <= gray;
        end
    end

    // row bookkeeping
    assign rw_ext   = WW'(row_width_reg);
    assign width    = (rw_ext == '0) ? WW'(1)
                    : ((rw_ext > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : rw_ext);
    assign wcol_inc = WW'(wcol_reg) + WW'(1);
    assign rcol_inc = WW'(rcol_reg) + WW'(1);
    assign wend     = wcol_inc >= width;
    assign rlast    = rcol_inc >= width;
    assign is_pix   = b_kind_reg == KIND_PIXEL;
    assign peak_new = (b_gray_reg > running_reg) ? b_gray_reg : running_reg;

    always_comb
    begin
        running_next = running_reg;
        held_next    = held_reg;
        wcol_next    = wcol_reg;
        rcol_next    = rcol_reg;
        bank_next    = bank_reg;
        pending_next = pending_reg;
        if (b_valid_reg)
        begin
            if (pending_reg)
            begin
                rcol_next    = rlast ? '0 : rcol_inc[CW-1:0];
                pending_next = !rlast;
            end
            if (is_pix)
            begin
                running_next = peak_new;
                wcol_next    = wcol_inc[CW-1:0];
                if (wend)
                begin
                    held_next    = peak_new;
                    running_next = 8'd0;
                    wcol_next    = '0;
                    bank_next    = !bank_reg;
                    pending_next = 1'b1;
                    rcol_next    = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 8'd0;
            held_reg    <= 8'd0;
            wcol_reg    <= '0;
            rcol_reg    <= '0;
            bank_reg    <= 1'b0;
            pending_reg <= 1'b0;
        end
        else
        begin
            running_reg <= running_next;
            held_reg    <= held_next;
            wcol_reg    <= wcol_next;
            rcol_reg    <= rcol_next;
            bank_reg    <= bank_next;
            pending_reg <= pending_next;
        end
    end

    always_comb
    begin
        push        = b_valid_reg && (pending_reg || is_pix);
        ctl.ren     = pending_reg;
        ctl.wen     = is_pix;
        ctl.rlast   = rlast;
        ctl.limit   = $signed({1'b0, held_reg}) - $signed({1'b0, light_range_reg});
        ctl.wdata   = b_gray_reg;
        raddr       = {!bank_reg, rcol_reg};
        waddr       = {bank_reg, wcol_reg};
        occ.a_valid = a_valid_reg;
        occ.b_valid = b_valid_reg;
    end

endmodule

`default_nettype wire

// ----- sv/rprt_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rprt_queue #(
    parameter int DATA_W = 8
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push,
    input  wire logic [DATA_W-1:0]           push_data,
    input  wire logic                        pop,
    output logic                             head_valid,
    output logic [DATA_W-1:0]                head_data,
    output logic [rprt_pkg::QCNT_W-1:0]      count
);
    import rprt_pkg::*;

    localparam int QAW = $clog2(QDEPTH);

    logic [DATA_W-1:0] slot_reg [QDEPTH];
    logic [QAW-1:0]    wptr_reg, rptr_reg;
    logic [QCNT_W-1:0] count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= wptr_reg + QAW'(1);
            if (pop)
                rptr_reg <= rptr_reg + QAW'(1);
            count_reg <= count_reg + QCNT_W'(push) - QCNT_W'(pop);
        end
    end

    assign head_valid = count_reg != '0;
    assign head_data  = slot_reg[rptr_reg];
    assign count      = count_reg;

endmodule

`default_nettype wire

// ----- sv/rprt_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rprt_back #(
    parameter int AW = 10
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                head_valid,
    input  wire rprt_pkg::cmd_ctl_t  ctl,
    input  wire logic [AW-1:0]       raddr,
    input  wire logic [AW-1:0]       waddr,
    output logic                     pop,
    rprt_res_if.source               results
);
    import rprt_pkg::*;

    logic [7:0]        store [2**AW];

    logic              rd_valid_reg;
    logic              rd_last_reg;
    logic signed [8:0] rd_limit_reg;
    logic [7:0]        rdata_reg;

    logic              out_valid_reg;
    logic [7:0]        out_pix_reg;
    logic              out_last_reg;

    logic              out_load, rd_advance, rd_load;
    logic [7:0]        pix_thr;

    assign out_load   = !out_valid_reg || results.ready;
    assign rd_advance = rd_valid_reg && out_load;
    assign pop        = head_valid && (!ctl.ren || !rd_valid_reg || out_load);
    assign rd_load    = pop && ctl.ren;

    always_ff @(posedge clk)
    begin
        if (pop && ctl.wen)
            store[waddr] <= ctl.wdata;
        if (rd_load)
        begin
            rdata_reg    <= store[raddr];
            rd_last_reg  <= ctl.rlast;
            rd_limit_reg <= ctl.limit;
        end
    end

    assign pix_thr = (rd_limit_reg > $signed({1'b0, rdata_reg})) ? 8'd0 : rdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rd_load)
                rd_valid_reg <= 1'b1;
            else if (rd_advance)
                rd_valid_reg <= 1'b0;
            if (out_load)
                out_valid_reg <= rd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_advance)
        begin
            out_pix_reg  <= pix_thr;
            out_last_reg <= rd_last_reg;
        end
    end

    assign results.valid     = out_valid_reg;
    assign results.pixel_out = out_pix_reg;
    assign results.row_end   = out_last_reg;

endmodule

`default_nettype wire
